// File: rtl/core/tcd_pkg.sv
package tcd_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int RECT_W     = 12;
  localparam int MIN_MONO_W = 7;
  localparam int PIX_W      = 8;
  localparam int POS_W      = 3;
  localparam int Q_DEPTH    = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_RECT_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_MONO_SIZE = 2'd1;

  localparam logic KIND_CLASS  = 1'b0;
  localparam logic KIND_BITMAP = 1'b1;

  localparam logic [1:0] CLS_SOLID = 2'd0;
  localparam logic [1:0] CLS_TWO   = 2'd1;
  localparam logic [1:0] CLS_MANY  = 2'd2;

  typedef enum logic {
    OP_CLASSIFY = 1'b0,
    OP_PACK     = 1'b1
  } op_t;

  // one decoded pixel handed from the front to the back
  typedef struct packed {
    op_t              op;
    logic [PIX_W-1:0] pixel;
    logic             last;
    logic [POS_W-1:0] pos;
    logic             flush;
  } cmd_t;

endpackage

// File: rtl/core/tcd_in_if.sv
interface tcd_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] pixel;
  logic       last;

  modport source (output valid, output op, output pixel, output last, input ready);
  modport sink (input valid, input op, input pixel, input last, output ready);
endinterface

// File: rtl/core/tcd_out_if.sv
interface tcd_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [1:0] color_class;
  logic       mono_ok;
  logic [7:0] background;
  logic [7:0] foreground;
  logic [7:0] bitmap_byte;
  logic       final_res;

  modport source (
    output valid, output kind, output color_class, output mono_ok,
    output background, output foreground, output bitmap_byte, output final_res,
    input ready
  );
  modport sink (
    input valid, input kind, input color_class, input mono_ok,
    input background, input foreground, input bitmap_byte, input final_res,
    output ready
  );
endinterface

// File: rtl/core/tcd_cfg_if.sv
interface tcd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [11:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/tcd_front.sv
module tcd_front
  import tcd_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic              clk,
  input  logic              rst_n,
  tcd_in_if.sink            in_ch,
  input  logic [RECT_W-1:0] rect_width,
  input  logic              q_full,
  output logic              q_push,
  output cmd_t              q_data
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W = ((CW + 1 > WW) ? CW + 1 : WW) + 1;

  logic [CW-1:0]    column_r, column_nxt;
  logic [CMP_W-1:0] width_eff;
  logic [CMP_W-1:0] col_plus;
  logic             row_end;
  logic [POS_W-1:0] pos;
  logic             accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign q_push      = accept;

  // clamp the configured width into 1..MAX_WIDTH
  always_comb begin
    if (rect_width == '0) begin
      width_eff = CMP_W'(1);
    end else if ({1'b0, rect_width} > 13'(MAX_WIDTH)) begin
      width_eff = CMP_W'(MAX_WIDTH);
    end else begin
      width_eff = CMP_W'(rect_width);
    end
  end

  assign col_plus = CMP_W'(column_r) + CMP_W'(1);
  assign row_end  = (col_plus >= width_eff);
  assign pos      = column_r[POS_W-1:0];

  always_comb begin
    q_data.op    = op_t'(in_ch.op);
    q_data.pixel = in_ch.pixel;
    q_data.last  = in_ch.last;
    q_data.pos   = pos;
    q_data.flush = (pos == 3'd7) || row_end || in_ch.last;

    column_nxt = column_r;
    if (accept && op_t'(in_ch.op) == OP_PACK) begin
      if (row_end || in_ch.last) begin
        column_nxt = '0;
      end else begin
        column_nxt = col_plus[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r <= '0;
    end else begin
      column_r <= column_nxt;
    end
  end

endmodule

// File: rtl/core/tcd_queue.sv
module tcd_queue
  import tcd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t wdata,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t rdata
);

  localparam int PW = $clog2(Q_DEPTH);
  localparam int NW = $clog2(Q_DEPTH + 1);

  cmd_t          mem_r [Q_DEPTH];
  logic [PW-1:0] wptr_r, rptr_r;
  logic [NW-1:0] count_r;

  assign full  = (count_r == NW'(Q_DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == PW'(Q_DEPTH - 1)) ? '0 : wptr_r + PW'(1);
      end
      if (pop) begin
        rptr_r <= (rptr_r == PW'(Q_DEPTH - 1)) ? '0 : rptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + NW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - NW'(1);
      end
    end
  end

endmodule

// File: rtl/core/tcd_back.sv
module tcd_back
  import tcd_pkg::*;
#(
  parameter int MAX_PIXELS = 65536
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  cmd_t                  q_data,
  output logic                  q_pop,
  input  logic [MIN_MONO_W-1:0] min_mono_size,
  tcd_out_if.source             out_ch
);

  localparam int CNT_W = $clog2(MAX_PIXELS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PIXELS);

  logic [PIX_W-1:0] first_color_r, first_color_nxt;
  logic [PIX_W-1:0] second_color_r, second_color_nxt;
  logic             have_second_r, have_second_nxt;
  logic             saw_third_r, saw_third_nxt;
  logic [CNT_W-1:0] first_cnt_r, first_cnt_nxt;
  logic [CNT_W-1:0] second_cnt_r, second_cnt_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic [PIX_W-1:0] stored_bg_r, stored_bg_nxt;
  logic [7:0]       acc_r, acc_nxt;

  logic             out_valid_r;
  logic             kind_r, kind_nxt;
  logic [1:0]       class_r, class_nxt;
  logic             mono_ok_r, mono_ok_nxt;
  logic [PIX_W-1:0] bg_r, bg_nxt;
  logic [PIX_W-1:0] fg_r, fg_nxt;
  logic [7:0]       bitmap_r, bitmap_nxt;
  logic             final_r, final_nxt;

  logic             emit;
  logic             out_free;
  logic [7:0]       acc_set;

  assign out_free = !out_valid_r || out_ch.ready;
  assign emit     = (q_data.op == OP_PACK) ? q_data.flush : q_data.last;
  assign q_pop    = !q_empty && (!emit || out_free);

  assign acc_set = (q_data.pixel != stored_bg_r) ? (8'h80 >> q_data.pos) : 8'h00;

  always_comb begin
    first_color_nxt  = first_color_r;
    second_color_nxt = second_color_r;
    have_second_nxt  = have_second_r;
    saw_third_nxt    = saw_third_r;
    first_cnt_nxt    = first_cnt_r;
    second_cnt_nxt   = second_cnt_r;
    total_nxt        = total_r;
    stored_bg_nxt    = stored_bg_r;
    acc_nxt          = acc_r;

    kind_nxt    = KIND_CLASS;
    class_nxt   = CLS_SOLID;
    mono_ok_nxt = 1'b0;
    bg_nxt      = '0;
    fg_nxt      = '0;
    bitmap_nxt  = '0;
    final_nxt   = 1'b1;

    if (q_data.op == OP_CLASSIFY) begin
      if (total_r == '0) begin
        first_color_nxt = q_data.pixel;
        first_cnt_nxt   = CNT_W'(1);
      end else if (q_data.pixel == first_color_r) begin
        first_cnt_nxt = (first_cnt_r < CNT_MAX) ? first_cnt_r + CNT_W'(1) : CNT_MAX;
      end else if (!have_second_r) begin
        second_color_nxt = q_data.pixel;
        have_second_nxt  = 1'b1;
        second_cnt_nxt   = CNT_W'(1);
      end else if (q_data.pixel == second_color_r) begin
        second_cnt_nxt = (second_cnt_r < CNT_MAX) ? second_cnt_r + CNT_W'(1) : CNT_MAX;
      end else begin
        saw_third_nxt = 1'b1;
      end
      total_nxt = (total_r < CNT_MAX) ? total_r + CNT_W'(1) : CNT_MAX;

      if (saw_third_nxt) begin
        class_nxt = CLS_MANY;
      end else if (have_second_nxt) begin
        class_nxt   = CLS_TWO;
        mono_ok_nxt = (total_nxt >= CNT_W'(min_mono_size));
        if (first_cnt_nxt >= second_cnt_nxt) begin
          bg_nxt = first_color_nxt;
          fg_nxt = second_color_nxt;
        end else begin
          bg_nxt = second_color_nxt;
          fg_nxt = first_color_nxt;
        end
      end else begin
        class_nxt = CLS_SOLID;
        bg_nxt    = first_color_nxt;
      end

      // close the pass: keep the background, restart the tracking
      if (q_data.last) begin
        stored_bg_nxt    = bg_nxt;
        first_color_nxt  = '0;
        second_color_nxt = '0;
        have_second_nxt  = 1'b0;
        saw_third_nxt    = 1'b0;
        first_cnt_nxt    = '0;
        second_cnt_nxt   = '0;
        total_nxt        = '0;
      end
    end else begin
      kind_nxt   = KIND_BITMAP;
      bg_nxt     = stored_bg_r;
      bitmap_nxt = acc_r | acc_set;
      final_nxt  = q_data.last;
      acc_nxt    = q_data.flush ? 8'h00 : (acc_r | acc_set);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_color_r  <= '0;
      second_color_r <= '0;
      have_second_r  <= 1'b0;
      saw_third_r    <= 1'b0;
      first_cnt_r    <= '0;
      second_cnt_r   <= '0;
      total_r        <= '0;
      stored_bg_r    <= '0;
      acc_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (q_pop) begin
        first_color_r  <= first_color_nxt;
        second_color_r <= second_color_nxt;
        have_second_r  <= have_second_nxt;
        saw_third_r    <= saw_third_nxt;
        first_cnt_r    <= first_cnt_nxt;
        second_cnt_r   <= second_cnt_nxt;
        total_r        <= total_nxt;
        stored_bg_r    <= stored_bg_nxt;
        acc_r          <= acc_nxt;
      end
      if (q_pop && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register, loaded only when the slot is free
  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      kind_r    <= kind_nxt;
      class_r   <= class_nxt;
      mono_ok_r <= mono_ok_nxt;
      bg_r      <= bg_nxt;
      fg_r      <= fg_nxt;
      bitmap_r  <= bitmap_nxt;
      final_r   <= final_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = kind_r;
  assign out_ch.color_class = class_r;
  assign out_ch.mono_ok     = mono_ok_r;
  assign out_ch.background  = bg_r;
  assign out_ch.foreground  = fg_r;
  assign out_ch.bitmap_byte = bitmap_r;
  assign out_ch.final_res   = final_r;

endmodule

// File: rtl/core/two_color_detect_and_mono_pack.sv
// Two-color detection and mono bitmap packing for 8-bit pixel rectangles. Stream a
// rectangle once with op 0 to get one classification transaction on the pixel marked
// last (solid / two colors / many, background, foreground, mono allowed), then again
// with op 1 to get packed bitmap bytes, MSB first, one every 8 pixels, at each row end
// and on the last pixel. Classify and pack pixels may be interleaved. The block takes
// one pixel per cycle while the queue is not full: the front tracks the pack column
// and the back updates the color counts, with a four-entry queue between them. A result
// is registered in the output register once its pixel leaves the queue. Write rect_width
// and min_mono_size only while no transaction is in flight.
module two_color_detect_and_mono_pack
  import tcd_pkg::*;
#(
  parameter int MAX_PIXELS = 65536,
  parameter int MAX_WIDTH  = 2048
) (
  input  logic       clk,
  input  logic       rst_n,
  tcd_in_if.sink     in_ch,
  tcd_out_if.source  out_ch,
  tcd_cfg_if.sink    cfg_ch
);

  logic [RECT_W-1:0]     rect_width_r;
  logic [MIN_MONO_W-1:0] min_mono_r;

  logic q_full, q_empty, q_push, q_pop;
  cmd_t q_wdata, q_rdata;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rect_width_r <= RECT_W'(1);
      min_mono_r   <= MIN_MONO_W'(6);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_RECT_WIDTH:    rect_width_r <= cfg_ch.data[RECT_W-1:0];
        CFG_MIN_MONO_SIZE: min_mono_r   <= cfg_ch.data[MIN_MONO_W-1:0];
        default: ;
      endcase
    end
  end

  tcd_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .rect_width (rect_width_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  tcd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  tcd_back #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_data        (q_rdata),
    .q_pop         (q_pop),
    .min_mono_size (min_mono_r),
    .out_ch        (out_ch)
  );

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import tcd_pkg::*;

  localparam int unsigned PIX_LIMIT   = 65536;
  localparam int unsigned WIDTH_LIMIT = 2048;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  typedef struct packed {
    logic       kind;
    logic [1:0] color_class;
    logic       mono_ok;
    logic [7:0] background;
    logic [7:0] foreground;
    logic [7:0] bitmap_byte;
    logic       final_res;
  } tcd_result_t;

  class mono_scoreboard;
    logic [11:0] rect_width;
    logic [6:0]  min_mono;
    logic [7:0]  first_color;
    logic [7:0]  second_color;
    bit          have_second;
    bit          saw_third;
    int unsigned first_count;
    int unsigned second_count;
    int unsigned pixel_total;
    logic [7:0]  stored_bg;
    int unsigned column;
    logic [7:0]  bits;
    tcd_result_t pending_results[$];
    int          errors;

    function new();
      rect_width = 12'd1;
      min_mono   = 7'd6;
      restart_classify();
      stored_bg = 8'h00;
      column    = 0;
      bits      = 8'h00;
      errors    = 0;
    endfunction

    function void restart_classify();
      first_color  = 8'h00;
      second_color = 8'h00;
      have_second  = 1'b0;
      saw_third    = 1'b0;
      first_count  = 0;
      second_count = 0;
      pixel_total  = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_RECT_WIDTH) begin
        rect_width = data;
      end else if (idx == CFG_MIN_MONO_SIZE) begin
        min_mono = data[6:0];
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void note_pixel(op_t op, logic [7:0] pix, logic last);
      tcd_result_t r;
      int unsigned w;
      int unsigned pos;
      bit          row_end;
      r = '0;
      if (op == OP_CLASSIFY) begin
        if (pixel_total == 0) begin
          first_color = pix;
          first_count = 1;
        end else if (pix == first_color) begin
          if (first_count < PIX_LIMIT) first_count++;
        end else if (!have_second) begin
          second_color = pix;
          have_second  = 1'b1;
          second_count = 1;
        end else if (pix == second_color) begin
          if (second_count < PIX_LIMIT) second_count++;
        end else begin
          saw_third = 1'b1;
        end
        if (pixel_total < PIX_LIMIT) pixel_total++;
        if (!last) return;
        r.kind      = KIND_CLASS;
        r.final_res = 1'b1;
        if (saw_third) begin
          r.color_class = CLS_MANY;
        end else if (have_second) begin
          r.color_class = CLS_TWO;
          // ties go to the color seen first
          if (first_count >= second_count) begin
            r.background = first_color;
            r.foreground = second_color;
          end else begin
            r.background = second_color;
            r.foreground = first_color;
          end
          r.mono_ok = (pixel_total >= min_mono);
        end else begin
          r.color_class = CLS_SOLID;
          r.background  = first_color;
        end
        stored_bg = r.background;
        restart_classify();
        pending_results.push_back(r);
      end else begin
        w = rect_width;
        if (w == 0) w = 1;
        if (w > WIDTH_LIMIT) w = WIDTH_LIMIT;
        pos = column & 7;
        if (pix != stored_bg) bits = bits | (8'h80 >> pos);
        row_end = (column + 1 >= w);
        if (pos != 7 && !row_end && !last) begin
          column = (column + 1) & 11'h7FF;
          return;
        end
        r.kind        = KIND_BITMAP;
        r.background  = stored_bg;
        r.bitmap_byte = bits;
        r.final_res   = last;
        bits = 8'h00;
        if (row_end || last) column = 0;
        else column = (column + 1) & 11'h7FF;
        pending_results.push_back(r);
      end
    endfunction

    function void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(tcd_result_t got);
      tcd_result_t exp_r;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transaction, expected none, actual %0h", $time, got);
        errors++;
        return;
      end
      exp_r = pending_results.pop_front();
      compare_field("kind", 8'(exp_r.kind), 8'(got.kind));
      compare_field("color_class", 8'(exp_r.color_class), 8'(got.color_class));
      compare_field("mono_ok", 8'(exp_r.mono_ok), 8'(got.mono_ok));
      compare_field("background", exp_r.background, got.background);
      compare_field("foreground", exp_r.foreground, got.foreground);
      compare_field("bitmap_byte", exp_r.bitmap_byte, got.bitmap_byte);
      compare_field("final_res", 8'(exp_r.final_res), 8'(got.final_res));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  tcd_in_if  in_ch();
  tcd_out_if out_ch();
  tcd_cfg_if cfg_ch();

  two_color_detect_and_mono_pack i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  mono_scoreboard sb;
  int send_idle;
  int recv_idle;
  int hold_req;
  int items_sent;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // result side: check each transaction, drive ready with random stalls and hold-offs
  initial begin
    tcd_result_t seen;
    int hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        seen.kind        = out_ch.kind;
        seen.color_class = out_ch.color_class;
        seen.mono_ok     = out_ch.mono_ok;
        seen.background  = out_ch.background;
        seen.foreground  = out_ch.foreground;
        seen.bitmap_byte = out_ch.bitmap_byte;
        seen.final_res   = out_ch.final_res;
        sb.check_result(seen);
      end
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic send_pixel(input op_t op, input logic [7:0] pix, input logic last);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.pixel <= pix;
    in_ch.last  <= last;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_pixel(op, pix, last);
    items_sent++;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_register(idx, data);
  endtask

  // upper data bits of the minimum size are junk and must be dropped
  task automatic apply_settings(input logic [11:0] width, input logic [6:0] min_size);
    logic [4:0] junk;
    junk = 5'($urandom_range(31));
    cfg_write(CFG_RECT_WIDTH, width);
    cfg_write(CFG_MIN_MONO_SIZE, {junk, min_size});
    cfg_ch.valid <= 1'b0;
  endtask

  // drop valid, wait for every owed result, then let the pipeline empty
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (16) @(posedge clk);
  endtask

  task automatic send_rect(input int n, input int palette);
    logic [7:0] colors [3];
    logic [7:0] px [$];
    for (int k = 0; k < 3; k++) colors[k] = 8'($urandom_range(255));
    for (int i = 0; i < n; i++) begin
      case (palette)
        0: px.push_back(colors[0]);
        1: px.push_back(colors[$urandom_range(1)]);
        default: begin
          if ($urandom_range(3) == 0) px.push_back(8'($urandom_range(255)));
          else px.push_back(colors[$urandom_range(2)]);
        end
      endcase
    end
    for (int i = 0; i < n; i++) send_pixel(OP_CLASSIFY, px[i], i == n - 1);
    for (int i = 0; i < n; i++) send_pixel(OP_PACK, px[i], i == n - 1);
  endtask

  task automatic run_random(input int target);
    int start;
    int n;
    start = items_sent;
    while (items_sent - start < target) begin
      if ($urandom_range(99) < 85) begin
        n = ($urandom_range(19) == 0) ? $urandom_range(64, 25) : $urandom_range(16, 1);
        send_rect(n, $urandom_range(2));
      end else begin
        // interleaved passes with stray last flags
        n = $urandom_range(12, 1);
        for (int i = 0; i < n; i++)
          send_pixel(op_t'($urandom_range(1)), 8'($urandom_range(255)),
                     $urandom_range(7) == 0);
      end
    end
    settle();
  endtask

  initial begin
    logic [11:0] widths [7];
    logic [6:0]  minimums [7];
    sb = new();
    widths   = '{12'd1, 12'd8, 12'd3, 12'd0, 12'd13, 12'd2048, 12'd4095};
    minimums = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd5, 7'd6, 7'd33};
    send_idle  = 31;
    recv_idle  = 47;
    hold_req   = 0;
    items_sent = 0;
    rst_n = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.op     = 1'b0;
    in_ch.pixel  = 8'h00;
    in_ch.last   = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_RECT_WIDTH;
    cfg_ch.data  = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: two colors tied, too few pixels for mono
    send_pixel(OP_CLASSIFY, 8'h00, 1'b0);
    send_pixel(OP_CLASSIFY, 8'hFF, 1'b1);
    send_pixel(OP_PACK, 8'hFF, 1'b0);
    send_pixel(OP_PACK, 8'h00, 1'b1);
    settle();
    cfg_write(CFG_IDX_UNUSED, 12'hFFF);
    apply_settings(12'd10, 7'd0);
    // solid, then two colors with the second more frequent, then many colors
    send_pixel(OP_CLASSIFY, 8'h55, 1'b1);
    send_pixel(OP_CLASSIFY, 8'hAA, 1'b0);
    send_pixel(OP_CLASSIFY, 8'h55, 1'b0);
    send_pixel(OP_CLASSIFY, 8'h55, 1'b1);
    send_pixel(OP_CLASSIFY, 8'h01, 1'b0);
    send_pixel(OP_CLASSIFY, 8'h02, 1'b0);
    send_pixel(OP_CLASSIFY, 8'h03, 1'b1);
    // full row with a byte boundary inside, then last in mid-row
    for (int i = 0; i < 10; i++) send_pixel(OP_PACK, (i % 2) ? 8'hFF : 8'h00, i == 9);
    for (int i = 0; i < 3; i++) send_pixel(OP_PACK, 8'hFF, i == 2);
    settle();

    for (int seg = 0; seg < 7; seg++) begin
      if (seg == 2) begin
        send_idle = 47;
        recv_idle = 31;
      end else if (seg == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      apply_settings(widths[seg], minimums[seg]);
      if (seg == 0) begin
        // hold the receiver off while one-pixel rows keep producing bytes
        hold_req = 300;
        for (int i = 0; i < 40; i++) send_pixel(OP_PACK, 8'($urandom_range(255)), i == 39);
        settle();
      end
      run_random(200);
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: two_color_detect_and_mono_pack.f
rtl/core/tcd_pkg.sv
rtl/core/tcd_in_if.sv
rtl/core/tcd_out_if.sv
rtl/core/tcd_cfg_if.sv
rtl/core/tcd_front.sv
rtl/core/tcd_queue.sv
rtl/core/tcd_back.sv
rtl/core/two_color_detect_and_mono_pack.sv
tb/sv/tb.sv
